// ----- hdl/obf_pkg.sv -----
package obf_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int MAX_OUT   = 64;

  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 7;
  localparam int STAT_W  = 2;
  localparam int LEVEL_W = 7;
  localparam int CAP_W   = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

  localparam logic [STAT_W-1:0] STAT_DATA  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_STREAM
  } state_t;

endpackage

// ----- hdl/overwriting_byte_fifo.sv -----
// Byte FIFO with a programmable capacity (cfg_data, clamped to 1..64) that drops its
// oldest byte when a push finds it full. An item is taken when start is high and busy is
// low. A push gives no result and leaves busy low, so pushes can be issued every cycle.
// A pop or peek of n bytes returns min(n, fill level, 64) results on consecutive cycles,
// one byte per cycle. busy rises in the cycle after the item is taken and stays high
// while a small sequencer steps a read pointer through the byte memory. The
// memory read is registered: the first byte appears behind the state and read-pointer
// registers and the read-data register, the last byte in the cycle in which busy falls,
// and the next item can be issued in that cycle. A zero-length request or one against
// an empty store returns a single status-only result in the cycle after it is taken, with
// busy left low. out_valid marks each result for exactly one cycle and results cannot be
// held off, so the receiver must take every strobed result. out_fill_level shows the
// level after the request completes. The capacity register accepts a write in every
// cycle but should only be written when no request is in flight.
module overwriting_byte_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [obf_pkg::FUNC_W-1:0]  in_func,
  input  logic [obf_pkg::BYTE_W-1:0]  in_data_byte,
  input  logic [obf_pkg::LEN_W-1:0]   in_request_length,
  output logic                        out_valid,
  output logic [obf_pkg::BYTE_W-1:0]  out_byte,
  output logic                        out_last,
  output logic [obf_pkg::STAT_W-1:0]  out_status,
  output logic [obf_pkg::LEVEL_W-1:0] out_fill_level,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [obf_pkg::CAP_W-1:0]   cfg_data
);
  import obf_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW = ((AW > LEVEL_W) ? AW : LEVEL_W) + 1;

  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                             input logic [LEVEL_W-1:0] b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [BYTE_W-1:0] mem [DEPTH];

  state_t             state_r, state_nxt;
  logic [CAP_W-1:0]   capacity_r;
  logic [AW-1:0]      head_r, head_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [AW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [LEN_W-1:0]   remain_r, remain_nxt;
  logic [BYTE_W-1:0]  rd_data_r;

  logic               out_valid_r, out_valid_nxt;
  logic               out_last_r, out_last_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [LEVEL_W-1:0] out_level_r;

  logic               accept;
  logic               is_req;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [LEVEL_W-1:0] cap_eff;
  logic [LEVEL_W-1:0] cnt;

  assign accept    = start && !busy;
  assign is_req    = (in_func == FUNC_POP) || (in_func == FUNC_PEEK);
  assign cfg_ready = 1'b1;

  always_comb begin
    cap_eff = LEVEL_W'(capacity_r);
    if (capacity_r == '0) begin
      cap_eff = LEVEL_W'(1);
    end else if (int'(capacity_r) > DEPTH) begin
      cap_eff = LEVEL_W'(DEPTH);
    end
  end

  always_comb begin
    cnt = (LEVEL_W'(in_request_length) < level_r) ? LEVEL_W'(in_request_length) : level_r;
    if (int'(cnt) > MAX_OUT) begin
      cnt = LEVEL_W'(MAX_OUT);
    end
  end

  assign wr_addr = ring_add(head_r, level_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && is_req && in_request_length != '0 && level_r != '0) begin
          state_nxt = ST_STREAM;
        end
      end
      ST_STREAM: begin
        if (remain_r == LEN_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    busy           = 1'b0;
    wr_en          = 1'b0;
    head_nxt       = head_r;
    level_nxt      = level_r;
    rd_ptr_nxt     = rd_ptr_r;
    remain_nxt     = remain_r;
    out_valid_nxt  = 1'b0;
    out_last_nxt   = 1'b0;
    out_status_nxt = STAT_DATA;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_func) inside
            FUNC_PUSH: begin
              wr_en = 1'b1;
              if (level_r >= cap_eff) begin
                head_nxt  = ring_add(head_r, level_r + LEVEL_W'(1) - cap_eff);
                level_nxt = cap_eff;
              end else begin
                level_nxt = level_r + LEVEL_W'(1);
              end
            end
            FUNC_POP, FUNC_PEEK: begin
              if (in_request_length == '0) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = STAT_ZERO;
              end else if (level_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                rd_ptr_nxt = head_r;
                remain_nxt = LEN_W'(cnt);
                if (in_func == FUNC_POP) begin
                  head_nxt  = ring_add(head_r, cnt);
                  level_nxt = level_r - cnt;
                end
              end
            end
            FUNC_NONE: ;
            default: ;
          endcase
        end
      end
      ST_STREAM: begin
        busy          = 1'b1;
        out_valid_nxt = 1'b1;
        out_last_nxt  = (remain_r == LEN_W'(1));
        rd_ptr_nxt    = ring_add(rd_ptr_r, LEVEL_W'(1));
        remain_nxt    = remain_r - LEN_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      capacity_r  <= CAP_RESET;
      head_r      <= '0;
      level_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      level_r     <= level_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        capacity_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r     <= rd_ptr_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_level_r  <= level_nxt;
  end

  // byte memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data_byte;
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  assign out_valid      = out_valid_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;
  assign out_fill_level = out_level_r;
  assign out_byte       = (out_status_r == STAT_DATA) ? rd_data_r : '0;

endmodule

// ----- hdl/obf_checker.sv -----
module obf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [obf_pkg::FUNC_W-1:0] in_func,
  input logic                       out_valid,
  input logic                       out_last,
  input logic [obf_pkg::STAT_W-1:0] out_status
);
  import obf_pkg::*;

  a_push_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_func == FUNC_PUSH |=> !out_valid)
    else $error("push produced a result");

  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_DATA |-> out_last)
    else $error("status-only item not marked last");

  a_stream_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && out_status == STAT_DATA)
    else $error("gap or bad status inside a byte stream");

  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_last)
    else $error("stream ended without a last item");

endmodule

bind overwriting_byte_fifo obf_checker u_obf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_func    (in_func),
  .out_valid  (out_valid),
  .out_last   (out_last),
  .out_status (out_status)
);
